// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the voice slot table RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PVST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define PVST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");
`else
`define PVST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PVST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/pvst_pkg.sv =====
// Shared types and constants for the priority voice slot table.
// No dependencies; used by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps

package pvst_pkg;

	// Table geometry.
	localparam int MAX_VOICES = 16;
	localparam int SLOT_W     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int CNT_W      = $clog2(MAX_VOICES + 1);

	// Field widths.
	localparam int KIND_W  = 2;
	localparam int ID_W    = 12;
	localparam int PRIO_W  = 16;
	localparam int INDEX_W = 4;
	localparam int ACT_W   = 5;
	localparam int CFG_W   = 5;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_READY  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_VOICES = 1'b1;

	// Reset values of the configuration registers.
	localparam logic             ENGINE_READY_RST  = 1'b1;
	localparam logic [ACT_W-1:0] ACTIVE_VOICES_RST = ACT_W'(16);

	// Operation codes.
	typedef enum logic [KIND_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_COMMIT,
		ST_READ,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;
		logic              clear_all;
		logic              issue;
		logic              scan;
		logic [SLOT_W-1:0] scan_addr;
		logic              commit;
		logic              finish;
	} ctrl_cmd_t;

	// One result transaction.
	typedef struct packed {
		logic               accepted;
		logic [INDEX_W-1:0] chosen_slot;
		logic               evicted_valid;
		logic [ID_W-1:0]    evicted_id;
		logic               read_valid;
		logic [ID_W-1:0]    read_id;
		logic [PRIO_W-1:0]  read_priority;
	} result_t;

endpackage

// ===== rtl/core/pvst_cmd_if.sv =====
// Command channel of the voice slot table: valid/ready plus operation fields.
// Depends on pvst_pkg for field widths.
`timescale 1ns / 1ps

interface pvst_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [pvst_pkg::KIND_W-1:0]  kind;
	logic [pvst_pkg::ID_W-1:0]    source_id;
	logic [pvst_pkg::PRIO_W-1:0]  new_priority;
	logic [pvst_pkg::INDEX_W-1:0] slot_index;

	modport source (output valid, kind, source_id, new_priority, slot_index, input ready);
	modport sink (input valid, kind, source_id, new_priority, slot_index, output ready);
endinterface

// ===== rtl/core/pvst_rsp_if.sv =====
// Result channel of the voice slot table: valid/ready plus result fields.
// Depends on pvst_pkg for field widths.
`timescale 1ns / 1ps

interface pvst_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         accepted;
	logic [pvst_pkg::INDEX_W-1:0] chosen_slot;
	logic                         evicted_valid;
	logic [pvst_pkg::ID_W-1:0]    evicted_id;
	logic                         read_valid;
	logic [pvst_pkg::ID_W-1:0]    read_id;
	logic [pvst_pkg::PRIO_W-1:0]  read_priority;

	modport source (output valid, accepted, chosen_slot, evicted_valid, evicted_id,
		read_valid, read_id, read_priority, input ready);
	modport sink (input valid, accepted, chosen_slot, evicted_valid, evicted_id,
		read_valid, read_id, read_priority, output ready);
endinterface

// ===== rtl/core/pvst_ctrl.sv =====
// Controller of the voice slot table: sequences scan, commit, read and result.
// Depends on pvst_pkg for state, command and width definitions.
`timescale 1ns / 1ps

module pvst_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic [pvst_pkg::KIND_W-1:0]  cmd_kind,
	output logic                         cmd_ready,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  logic                         engine_ready,
	input  logic [pvst_pkg::ACT_W-1:0]   active_voices,
	output pvst_pkg::ctrl_cmd_t          ctl
);

	pvst_pkg::state_t               state_q, state_d;
	logic [pvst_pkg::CNT_W-1:0]     scan_q;
	logic [pvst_pkg::CNT_W-1:0]     last_slot;
	logic                           rsp_valid_q;
	logic                           out_free;
	pvst_pkg::op_t                  op;

	assign op = pvst_pkg::op_t'(cmd_kind);

	// Number of live slots, clamped to 1..MAX_VOICES, minus one.
	always_comb begin
		if (active_voices == '0) begin
			last_slot = '0;
		end else if (32'(active_voices) > pvst_pkg::MAX_VOICES) begin
			last_slot = pvst_pkg::CNT_W'(pvst_pkg::MAX_VOICES - 1);
		end else begin
			last_slot = pvst_pkg::CNT_W'(active_voices) - pvst_pkg::CNT_W'(1);
		end
	end

	assign out_free = !rsp_valid_q || rsp_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pvst_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (op)
						pvst_pkg::OP_INSERT,
						pvst_pkg::OP_REMOVE: begin
							state_d = engine_ready ? pvst_pkg::ST_SCAN : pvst_pkg::ST_DONE;
						end
						pvst_pkg::OP_READ: state_d = pvst_pkg::ST_READ;
						default: state_d = pvst_pkg::ST_DONE;
					endcase
				end
			end
			pvst_pkg::ST_SCAN: begin
				if (scan_q == last_slot) begin
					state_d = pvst_pkg::ST_WAIT;
				end
			end
			pvst_pkg::ST_WAIT:   state_d = pvst_pkg::ST_COMMIT;
			pvst_pkg::ST_COMMIT: state_d = pvst_pkg::ST_DONE;
			pvst_pkg::ST_READ:   state_d = pvst_pkg::ST_DONE;
			pvst_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pvst_pkg::ST_IDLE;
				end
			end
			default: state_d = pvst_pkg::ST_IDLE;
		endcase
	end

	// Outputs decoded from the state.
	always_comb begin
		cmd_ready     = (state_q == pvst_pkg::ST_IDLE);
		ctl.load      = (state_q == pvst_pkg::ST_IDLE) && cmd_valid;
		ctl.clear_all = (state_q == pvst_pkg::ST_IDLE) && cmd_valid
			&& (op == pvst_pkg::OP_CLEAR);
		ctl.issue     = (state_q == pvst_pkg::ST_SCAN) || (state_q == pvst_pkg::ST_READ);
		ctl.scan      = (state_q == pvst_pkg::ST_SCAN);
		ctl.scan_addr = scan_q[pvst_pkg::SLOT_W-1:0];
		ctl.commit    = (state_q == pvst_pkg::ST_COMMIT);
		ctl.finish    = (state_q == pvst_pkg::ST_DONE) && out_free;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Slot scan counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctl.load) begin
			scan_q <= '0;
		end else if (state_q == pvst_pkg::ST_SCAN) begin
			scan_q <= scan_q + pvst_pkg::CNT_W'(1);
		end
	end

	// Result valid flag; the result register sits in the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== rtl/core/pvst_dp.sv =====
// Datapath of the voice slot table: slot memory, occupancy bits, scan
// accumulators and the result register. Depends on pvst_pkg.
`timescale 1ns / 1ps

module pvst_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pvst_pkg::ctrl_cmd_t          ctl,
	input  logic [pvst_pkg::KIND_W-1:0]  in_kind,
	input  logic [pvst_pkg::ID_W-1:0]    in_id,
	input  logic [pvst_pkg::PRIO_W-1:0]  in_prio,
	input  logic [pvst_pkg::INDEX_W-1:0] in_index,
	output pvst_pkg::result_t            res
);

	localparam int ENTRY_W = pvst_pkg::ID_W + pvst_pkg::PRIO_W;

	// Slot memory holds {source id, priority}.
	logic [ENTRY_W-1:0]                mem [pvst_pkg::MAX_VOICES];
	logic [pvst_pkg::MAX_VOICES-1:0]   occ_q;

	// Latched transaction.
	pvst_pkg::op_t                     kind_q;
	logic [pvst_pkg::ID_W-1:0]         id_q;
	logic [pvst_pkg::PRIO_W-1:0]       prio_q;
	logic [pvst_pkg::INDEX_W-1:0]      index_q;

	// Read pipeline stage.
	logic [ENTRY_W-1:0]                rd_s1;
	logic [pvst_pkg::SLOT_W-1:0]       idx_s1;
	logic                              eval_s1;
	logic [pvst_pkg::SLOT_W-1:0]       rd_addr;
	logic [pvst_pkg::ID_W-1:0]         rd_src;
	logic [pvst_pkg::PRIO_W-1:0]       rd_prio;
	logic                              rd_occ;

	// Scan accumulators.
	logic                              found_empty_q;
	logic                              best_valid_q;
	logic [pvst_pkg::SLOT_W-1:0]       best_idx_q;
	logic [pvst_pkg::PRIO_W-1:0]       best_prio_q;
	logic [pvst_pkg::ID_W-1:0]         best_src_q;
	logic                              match_q;

	// Decision registers.
	logic                              acc_q;
	logic [pvst_pkg::INDEX_W-1:0]      chosen_q;
	logic                              ev_valid_q;
	logic [pvst_pkg::ID_W-1:0]         ev_id_q;

	logic                              ins_win;
	logic                              rm_hit;
	logic                              ins_eval;
	logic                              read_in_range;
	logic [pvst_pkg::SLOT_W-1:0]       read_slot;

	assign read_slot = pvst_pkg::SLOT_W'(index_q);
	assign rd_addr   = ctl.scan ? ctl.scan_addr : read_slot;
	assign rd_src    = rd_s1[ENTRY_W-1:pvst_pkg::PRIO_W];
	assign rd_prio   = rd_s1[pvst_pkg::PRIO_W-1:0];
	assign rd_occ    = occ_q[idx_s1];

	// Evaluation of the entry coming out of the read stage.
	assign ins_eval = eval_s1 && (kind_q == pvst_pkg::OP_INSERT) && !found_empty_q;
	assign rm_hit   = eval_s1 && (kind_q == pvst_pkg::OP_REMOVE) && rd_occ && (rd_src == id_q);

	// An empty slot competes with priority zero; the new priority must be strictly higher.
	assign ins_win = best_valid_q && ((found_empty_q ? '0 : best_prio_q) < prio_q);

	// Memory write on a winning insert, registered read.
	always_ff @(posedge clk) begin
		if (ctl.commit && (kind_q == pvst_pkg::OP_INSERT) && ins_win) begin
			mem[best_idx_q] <= {id_q, prio_q};
		end
		if (ctl.issue) begin
			rd_s1  <= mem[rd_addr];
			idx_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= ctl.issue && ctl.scan;
		end
	end

	// Occupancy bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctl.clear_all) begin
			occ_q <= '0;
		end else if (ctl.commit && (kind_q == pvst_pkg::OP_INSERT) && ins_win) begin
			occ_q[best_idx_q] <= 1'b1;
		end else if (rm_hit) begin
			occ_q[idx_s1] <= 1'b0;
		end
	end

	// Transaction latch.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q  <= pvst_pkg::op_t'(in_kind);
			id_q    <= in_id;
			prio_q  <= in_prio;
			index_q <= in_index;
		end
	end

	// Scan accumulators: first empty slot, else first lowest priority.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_empty_q <= 1'b0;
			best_valid_q  <= 1'b0;
			best_idx_q    <= '0;
			best_prio_q   <= '0;
			best_src_q    <= '0;
			match_q       <= 1'b0;
		end else if (ctl.load) begin
			found_empty_q <= 1'b0;
			best_valid_q  <= 1'b0;
			match_q       <= 1'b0;
		end else begin
			if (ins_eval) begin
				if (!rd_occ) begin
					found_empty_q <= 1'b1;
					best_valid_q  <= 1'b1;
					best_idx_q    <= idx_s1;
					best_prio_q   <= '0;
				end else if (!best_valid_q || (rd_prio < best_prio_q)) begin
					best_valid_q  <= 1'b1;
					best_idx_q    <= idx_s1;
					best_prio_q   <= rd_prio;
					best_src_q    <= rd_src;
				end
			end
			if (rm_hit) begin
				match_q <= 1'b1;
			end
		end
	end

	// Decision registers, cleared per transaction and set at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= 1'b0;
			chosen_q   <= '0;
			ev_valid_q <= 1'b0;
			ev_id_q    <= '0;
		end else if (ctl.load) begin
			acc_q      <= 1'b0;
			chosen_q   <= '0;
			ev_valid_q <= 1'b0;
			ev_id_q    <= '0;
		end else if (ctl.commit) begin
			if (kind_q == pvst_pkg::OP_INSERT) begin
				if (ins_win) begin
					acc_q      <= 1'b1;
					chosen_q   <= pvst_pkg::INDEX_W'(best_idx_q);
					ev_valid_q <= !found_empty_q;
					ev_id_q    <= found_empty_q ? '0 : best_src_q;
				end
			end else begin
				acc_q <= match_q;
			end
		end
	end

	assign read_in_range = 32'(index_q) < pvst_pkg::MAX_VOICES;

	// Result register.
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			if (kind_q == pvst_pkg::OP_READ) begin
				res.accepted      <= 1'b0;
				res.chosen_slot   <= '0;
				res.evicted_valid <= 1'b0;
				res.evicted_id    <= '0;
				if (read_in_range && occ_q[read_slot]) begin
					res.read_valid    <= 1'b1;
					res.read_id       <= rd_src;
					res.read_priority <= rd_prio;
				end else begin
					res.read_valid    <= 1'b0;
					res.read_id       <= '0;
					res.read_priority <= '0;
				end
			end else begin
				res.accepted      <= acc_q;
				res.chosen_slot   <= chosen_q;
				res.evicted_valid <= ev_valid_q;
				res.evicted_id    <= ev_id_q;
				res.read_valid    <= 1'b0;
				res.read_id       <= '0;
				res.read_priority <= '0;
			end
		end
	end

endmodule

// ===== rtl/core/priority_voice_slot_table.sv =====
// Priority voice slot table: inserts sources into voice slots, stealing the
// lowest-priority slot when full if the new priority is strictly higher; one
// transaction in flight at a time. With the engine ready, an insert or remove scans
// the live slots (active_voices clamped to 1..16) of the single-port slot memory one
// slot per cycle, then passes the wait, commit and done states; a read passes read
// and done, a clear only done. A finished result waits in an output register, so
// the next command is taken while it is still unclaimed; that command then holds in
// its last cycle until the waiting result is taken. The user must write configuration
// through cfg_we/cfg_idx/cfg_data while no command is in flight; nothing enforces it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module priority_voice_slot_table (
	input  logic                           clk,
	input  logic                           arst_n,
	pvst_cmd_if.sink                       cmd,
	pvst_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [pvst_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [pvst_pkg::CFG_W-1:0]     cfg_data
);

	logic                         engine_ready_q;
	logic [pvst_pkg::ACT_W-1:0]   active_voices_q;
	pvst_pkg::ctrl_cmd_t          ctl;
	pvst_pkg::result_t            res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engine_ready_q  <= pvst_pkg::ENGINE_READY_RST;
			active_voices_q <= pvst_pkg::ACTIVE_VOICES_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				pvst_pkg::CFG_ENGINE_READY:  engine_ready_q  <= cfg_data[0];
				pvst_pkg::CFG_ACTIVE_VOICES: active_voices_q <= cfg_data[pvst_pkg::ACT_W-1:0];
				default: ;
			endcase
		end
	end

	pvst_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd.valid),
		.cmd_kind     (cmd.kind),
		.cmd_ready    (cmd.ready),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.engine_ready (engine_ready_q),
		.active_voices(active_voices_q),
		.ctl          (ctl)
	);

	pvst_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_kind  (cmd.kind),
		.in_id    (cmd.source_id),
		.in_prio  (cmd.new_priority),
		.in_index (cmd.slot_index),
		.res      (res)
	);

	// Result fields onto the channel.
	assign rsp.accepted      = res.accepted;
	assign rsp.chosen_slot   = res.chosen_slot;
	assign rsp.evicted_valid = res.evicted_valid;
	assign rsp.evicted_id    = res.evicted_id;
	assign rsp.read_valid    = res.read_valid;
	assign rsp.read_id       = res.read_id;
	assign rsp.read_priority = res.read_priority;

	// Only one transaction is in flight: ready drops right after an acceptance.
	`PVST_ASSERT_NXT(a_one_in_flight, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready)
	// An eviction is only reported for an insert that was placed.
	`PVST_ASSERT_IMP(a_evict_needs_accept, clk, arst_n, rsp.valid && rsp.evicted_valid, rsp.accepted)
	// Read results and insert/remove results never mix.
	`PVST_ASSERT_IMP(a_read_exclusive, clk, arst_n, rsp.valid && rsp.read_valid,
		!rsp.accepted && !rsp.evicted_valid)

endmodule

// ===== tb/priority_voice_slot_table_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the priority voice slot table: directed and random slot traffic,
// checked against a mirror of the table kept by a scoreboard class.
// Depends on pvst_pkg, pvst_cmd_if, pvst_rsp_if and priority_voice_slot_table.

module priority_voice_slot_table_test;
	import pvst_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 400;
	// Starting point of the lowest-priority search; above any 16-bit priority.
	localparam int PRIO_CEILING  = 1000000;

	typedef struct {
		op_t                kind;
		logic [ID_W-1:0]    source_id;
		logic [PRIO_W-1:0]  new_priority;
		logic [INDEX_W-1:0] slot_index;
	} voice_cmd_t;

	// Mirror of the slot table plus the queue of results it predicts.
	class voice_table_scoreboard;
		bit                engine_up;
		logic [ACT_W-1:0]  active_raw;
		bit                held [MAX_VOICES];
		logic [ID_W-1:0]   held_id [MAX_VOICES];
		logic [PRIO_W-1:0] held_prio [MAX_VOICES];
		result_t           pending_outcomes [$];
		int                failures;

		function new();
			engine_up = ENGINE_READY_RST;
			active_raw = ACTIVE_VOICES_RST;
			failures = 0;
			foreach (held[i]) begin
				held[i] = 1'b0;
				held_id[i] = '0;
				held_prio[i] = '0;
			end
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == CFG_ENGINE_READY) begin
				engine_up = data[0];
			end else begin
				active_raw = data[ACT_W-1:0];
			end
		endfunction

		// Active slot count, clamped to 1..MAX_VOICES.
		function int live_slots();
			int n;
			n = active_raw;
			if (n < 1) n = 1;
			if (n > MAX_VOICES) n = MAX_VOICES;
			return n;
		endfunction

		function int outstanding();
			return pending_outcomes.size();
		endfunction

		// Apply one accepted command to the mirror and queue its result.
		function void note_command(voice_cmd_t c);
			result_t r;
			int n;
			int pick;
			int pick_prio;
			r = '0;
			n = live_slots();
			case (c.kind)
			OP_INSERT: begin
				if (engine_up) begin
					pick = -1;
					pick_prio = PRIO_CEILING;
					// First empty slot wins; otherwise the first with the lowest priority.
					for (int i = 0; i < n; i++) begin
						if (!held[i]) begin
							pick = i;
							pick_prio = 0;
							break;
						end
						if (int'(held_prio[i]) < pick_prio) begin
							pick = i;
							pick_prio = int'(held_prio[i]);
						end
					end
					// The slot is taken only by a strictly higher priority.
					if (pick >= 0 && pick_prio < int'(c.new_priority)) begin
						r.accepted = 1'b1;
						r.chosen_slot = pick[INDEX_W-1:0];
						if (held[pick]) begin
							r.evicted_valid = 1'b1;
							r.evicted_id = held_id[pick];
						end
						held[pick] = 1'b1;
						held_id[pick] = c.source_id;
						held_prio[pick] = c.new_priority;
					end
				end
			end
			OP_REMOVE: begin
				if (engine_up) begin
					for (int i = 0; i < n; i++) begin
						if (held[i] && held_id[i] == c.source_id) begin
							held[i] = 1'b0;
							r.accepted = 1'b1;
						end
					end
				end
			end
			OP_CLEAR: begin
				foreach (held[i]) held[i] = 1'b0;
			end
			default: begin
				if (c.slot_index < MAX_VOICES && held[c.slot_index]) begin
					r.read_valid = 1'b1;
					r.read_id = held_id[c.slot_index];
					r.read_priority = held_prio[c.slot_index];
				end
			end
			endcase
			pending_outcomes.push_back(r);
		endfunction

		function void match_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				failures++;
			end
		endfunction

		// Compare one result transaction with the oldest prediction.
		function void check_result(result_t got);
			result_t want;
			if (pending_outcomes.size() == 0) begin
				$error("result transaction with no command outstanding");
				failures++;
				return;
			end
			want = pending_outcomes.pop_front();
			match_field("accepted", want.accepted, got.accepted);
			match_field("chosen_slot", want.chosen_slot, got.chosen_slot);
			match_field("evicted_valid", want.evicted_valid, got.evicted_valid);
			match_field("evicted_id", want.evicted_id, got.evicted_id);
			match_field("read_valid", want.read_valid, got.read_valid);
			match_field("read_id", want.read_id, got.read_id);
			match_field("read_priority", want.read_priority, got.read_priority);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	int                   cycle_count = 0;
	int                   burst_left;
	bit                   hold_request;
	logic [ID_W-1:0]      recent_ids [$];
	voice_table_scoreboard tracker;

	pvst_cmd_if cmd_if ();
	pvst_rsp_if rsp_if ();

	priority_voice_slot_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side: check each transaction and drive ready on a changing pattern.
	initial begin : result_side
		int mode;
		int mode_left;
		int hold_left;
		int beat;
		result_t got;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		beat = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				got.accepted = rsp_if.accepted;
				got.chosen_slot = rsp_if.chosen_slot;
				got.evicted_valid = rsp_if.evicted_valid;
				got.evicted_id = rsp_if.evicted_id;
				got.read_valid = rsp_if.read_valid;
				got.read_id = rsp_if.read_id;
				got.read_priority = rsp_if.read_priority;
				tracker.check_result(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			beat++;
			// A long hold-off lets the block fill up and stall its input.
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				case (mode)
				0: rsp_if.ready <= 1'b1;
				1: rsp_if.ready <= 1'($urandom_range(0, 1));
				2: rsp_if.ready <= (beat % 4 == 0);
				default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Offer one command and wait until it is accepted; gaps come between bursts.
	task automatic push_command(op_t kind, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
			logic [INDEX_W-1:0] idx);
		voice_cmd_t c;
		int gap;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		c.kind = kind;
		c.source_id = id;
		c.new_priority = prio;
		c.slot_index = idx;
		cmd_if.valid <= 1'b1;
		cmd_if.kind <= kind;
		cmd_if.source_id <= id;
		cmd_if.new_priority <= prio;
		cmd_if.slot_index <= idx;
		@(posedge clk);
		while (cmd_if.ready !== 1'b1) @(posedge clk);
		tracker.note_command(c);
		burst_left--;
	endtask

	// Stop offering and wait for every predicted result to come back.
	task automatic wait_table_idle();
		cmd_if.valid <= 1'b0;
		burst_left = 0;
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	// Write both configuration registers, one per cycle.
	task automatic write_settings(bit ready, logic [CFG_W-1:0] active);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_ENGINE_READY;
		cfg_data <= CFG_W'(ready);
		@(posedge clk);
		tracker.set_register(CFG_ENGINE_READY, CFG_W'(ready));
		cfg_idx <= CFG_ACTIVE_VOICES;
		cfg_data <= active;
		@(posedge clk);
		tracker.set_register(CFG_ACTIVE_VOICES, active);
		cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		// Full table size: field extremes, zero priority, removes with and without a match.
		push_command(OP_READ, 12'h000, 16'h0000, 4'd0);
		push_command(OP_INSERT, 12'hFFF, 16'h0000, 4'd0);
		push_command(OP_INSERT, 12'h000, 16'h0001, 4'd0);
		push_command(OP_INSERT, 12'hABC, 16'hFFFF, 4'd0);
		push_command(OP_READ, 12'h000, 16'h0000, 4'd0);
		push_command(OP_READ, 12'hFFF, 16'hFFFF, 4'd1);
		push_command(OP_REMOVE, 12'h123, 16'h0000, 4'd0);
		push_command(OP_REMOVE, 12'h000, 16'h0000, 4'd0);
		push_command(OP_READ, 12'h000, 16'h0000, 4'd0);
		push_command(OP_INSERT, 12'h555, 16'hAAAA, 4'd0);
		push_command(OP_INSERT, 12'h2AA, 16'h5555, 4'd0);
		push_command(OP_READ, 12'h000, 16'h0000, 4'd15);
		wait_table_idle();

		// Zero active voices acts as one: stealing, equal priority, slots past the active range.
		write_settings(1'b1, 5'd0);
		push_command(OP_INSERT, 12'h007, 16'h0003, 4'd0);
		push_command(OP_INSERT, 12'h007, 16'hFFFF, 4'd0);
		push_command(OP_INSERT, 12'h008, 16'hFFFF, 4'd0);
		push_command(OP_READ, 12'h000, 16'h0000, 4'd2);
		push_command(OP_REMOVE, 12'h2AA, 16'h0000, 4'd0);
		wait_table_idle();

		// Engine down: insert and remove are ignored, clear still acts.
		write_settings(1'b0, 5'd16);
		push_command(OP_INSERT, 12'h009, 16'd100, 4'd0);
		push_command(OP_REMOVE, 12'h007, 16'h0000, 4'd0);
		push_command(OP_CLEAR, 12'h000, 16'h0000, 4'd0);
		push_command(OP_READ, 12'h000, 16'h0000, 4'd0);
		wait_table_idle();
	endtask

	// One random command; removes mostly target ids that were inserted lately.
	task automatic push_random_item();
		int roll;
		int sel;
		op_t kind;
		logic [ID_W-1:0] id;
		logic [PRIO_W-1:0] prio;
		roll = $urandom_range(0, 99);
		sel = $urandom_range(0, 9);
		id = ($urandom_range(0, 2) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 23));
		if (sel == 0) prio = '0;
		else if (sel == 1) prio = '1;
		else if (sel < 6) prio = PRIO_W'($urandom_range(1, 6));
		else prio = PRIO_W'($urandom);
		if (roll < 48) begin
			kind = OP_INSERT;
			recent_ids.push_back(id);
			if (recent_ids.size() > 32) void'(recent_ids.pop_front());
		end else if (roll < 68) begin
			kind = OP_REMOVE;
			if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0)
				id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
		end else if (roll < 98) begin
			kind = OP_READ;
		end else begin
			kind = OP_CLEAR;
		end
		push_command(kind, id, prio, INDEX_W'($urandom));
	endtask

	task automatic run_random();
		logic [CFG_W-1:0] phase_active [10] = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd12,
			5'd0, 5'd17, 5'd3, 5'd16, 5'd16};
		bit phase_ready [10] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
		int count;
		for (int p = 0; p < 10; p++) begin
			if (p > 0) wait_table_idle();
			write_settings(phase_ready[p], phase_active[p]);
			count = phase_ready[p] ? 110 : 40;
			for (int j = 0; j < count; j++) begin
				if (j == 30 && (p == 1 || p == 8)) hold_request = 1'b1;
				push_random_item();
			end
		end
	endtask

	// Reset, directed part, random phases, then drain and report.
	initial begin : stimulus
		tracker = new();
		burst_left = 0;
		hold_request = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_ENGINE_READY;
		cfg_data <= '0;
		cmd_if.valid <= 1'b0;
		cmd_if.kind <= OP_INSERT;
		cmd_if.source_id <= '0;
		cmd_if.new_priority <= '0;
		cmd_if.slot_index <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		wait_table_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
